[sv/nps_pkg.sv]
package nps_pkg;

  localparam int unsigned PALETTE_ENTRIES_DEF = 256;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned DIST_W  = 18;
  // Each RAM word holds the allowed mark above red, green and blue.
  localparam int unsigned WORD_W  = 3 * COLOR_W + 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_FINAL
  } state_e;

  typedef struct packed {
    logic             last;
    logic             allowed;
    logic [IDX_W-1:0] idx;
  } entry_meta_t;

  typedef struct packed {
    logic              vld;
    entry_meta_t       meta;
    logic [DIST_W-1:0] dist_sq;
  } dist_res_t;

endpackage

[sv/nps_ram.sv]
module nps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/nps_dist.sv]
module nps_dist
  import nps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  entry_meta_t        meta_i,
  input  logic [COLOR_W-1:0] ent_r_i,
  input  logic [COLOR_W-1:0] ent_g_i,
  input  logic [COLOR_W-1:0] ent_b_i,
  input  logic [COLOR_W-1:0] qry_r_i,
  input  logic [COLOR_W-1:0] qry_g_i,
  input  logic [COLOR_W-1:0] qry_b_i,
  output dist_res_t          res_o
);

  localparam int unsigned SQ_W = 2 * COLOR_W;

  logic [COLOR_W-1:0] dr, dg, db;
  logic [SQ_W-1:0]    sr, sg, sb;
  logic [DIST_W-1:0]  dist_d, dist_q;
  logic               vld_q;
  entry_meta_t        meta_q;

  // Absolute differences keep the squares unsigned and narrow.
  assign dr = (qry_r_i >= ent_r_i) ? qry_r_i - ent_r_i : ent_r_i - qry_r_i;
  assign dg = (qry_g_i >= ent_g_i) ? qry_g_i - ent_g_i : ent_g_i - qry_g_i;
  assign db = (qry_b_i >= ent_b_i) ? qry_b_i - ent_b_i : ent_b_i - qry_b_i;

  assign sr = SQ_W'(dr) * SQ_W'(dr);
  assign sg = SQ_W'(dg) * SQ_W'(dg);
  assign sb = SQ_W'(db) * SQ_W'(db);

  assign dist_d = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    meta_q <= meta_i;
  end

  assign res_o.vld     = vld_q;
  assign res_o.meta    = meta_q;
  assign res_o.dist_sq = dist_q;

endmodule

[sv/nearest_palette_color_search_top.sv]
// Write item: accepted while idle, no result.
// Query item: the palette RAM is walked, the distance unit drained and the result loaded;
// the next item is taken only after that, later while a result waits.
// The walk over the palette RAM reads one entry per cycle through the single read port
// and the shared distance unit.
// Reset clears the per-entry valid flops at once, so every entry reads as black and
// not allowed right after reset; there is no clearing pass.
module nearest_palette_color_search_top
  import nps_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic [IDX_W-1:0]      entry_index_i,
  input  logic [COLOR_W-1:0]    red_i,
  input  logic [COLOR_W-1:0]    green_i,
  input  logic [COLOR_W-1:0]    blue_i,
  input  logic                  allowed_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [IDX_W-1:0]      nearest_index_o,
  output logic [DIST_W-1:0]     distance_o
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

  state_e              state_q, state_d;
  logic [AW-1:0]       cnt_q, cnt_d;
  logic [PALETTE_ENTRIES-1:0] valid_q;
  logic [COLOR_W-1:0]  qr_q, qg_q, qb_q;

  logic                in_fire, wr_en, in_range, walk_last;
  logic                issue, load_out, out_free;
  logic [AW-1:0]       ram_addr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;

  logic                p1_vld_q, p1_ok_q;
  logic                p1_last_q;
  logic [AW-1:0]       p1_idx_q;
  entry_meta_t         p1_meta;
  logic [COLOR_W-1:0]  ent_r, ent_g, ent_b;
  dist_res_t           res;

  logic                found_q;
  logic [IDX_W-1:0]    best_idx_q;
  logic [DIST_W-1:0]   best_dist_q, d0_q;
  logic                out_valid_q;
  logic [IDX_W-1:0]    out_idx_q;
  logic [DIST_W-1:0]   out_dist_q;

  assign in_fire   = in_valid_i && in_ready_o;
  assign in_range  = {1'b0, entry_index_i} < (IDX_W + 1)'(PALETTE_ENTRIES);
  assign wr_en     = in_fire && (operation_i == OP_WRITE) && in_range;
  assign walk_last = (cnt_q == AW'(PALETTE_ENTRIES - 1));
  assign out_free  = !out_valid_q || out_ready_i;

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && operation_i == OP_QUERY) state_d = S_WALK;
      end
      S_WALK: begin
        if (walk_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (res.vld && res.meta.last) state_d = S_FINAL;
      end
      S_FINAL: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      S_WALK:  issue      = 1'b1;
      S_DRAIN: ;
      S_FINAL: load_out   = out_free;
      default: ;
    endcase
  end

  assign cnt_d = issue ? (walk_last ? '0 : cnt_q + AW'(1)) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (wr_en) valid_q[entry_index_i[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && operation_i == OP_QUERY) begin
      qr_q <= red_i;
      qg_q <= green_i;
      qb_q <= blue_i;
    end
  end

  assign ram_addr  = wr_en ? entry_index_i[AW-1:0] : cnt_q;
  assign ram_wdata = {allowed_i, red_i, green_i, blue_i};

  nps_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Side information travels alongside the registered RAM read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_ok_q   <= valid_q[cnt_q];
    p1_last_q <= walk_last;
    p1_idx_q  <= cnt_q;
  end

  // An entry never written reads as black and not allowed.
  assign ent_r = p1_ok_q ? ram_rdata[3*COLOR_W-1:2*COLOR_W] : '0;
  assign ent_g = p1_ok_q ? ram_rdata[2*COLOR_W-1:COLOR_W]   : '0;
  assign ent_b = p1_ok_q ? ram_rdata[COLOR_W-1:0]           : '0;

  assign p1_meta.last    = p1_last_q;
  assign p1_meta.allowed = p1_ok_q && ram_rdata[WORD_W-1];
  assign p1_meta.idx     = IDX_W'(p1_idx_q);

  nps_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (p1_vld_q),
    .meta_i  (p1_meta),
    .ent_r_i (ent_r),
    .ent_g_i (ent_g),
    .ent_b_i (ent_b),
    .qry_r_i (qr_q),
    .qry_g_i (qg_q),
    .qry_b_i (qb_q),
    .res_o   (res)
  );

  // Running best; a new entry wins only when strictly closer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (in_fire && operation_i == OP_QUERY) begin
      found_q <= 1'b0;
    end else if (res.vld && res.meta.allowed) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.vld) begin
      if (res.meta.idx == '0) d0_q <= res.dist_sq;
      if (res.meta.allowed && (!found_q || res.dist_sq < best_dist_q)) begin
        best_dist_q <= res.dist_sq;
        best_idx_q  <= res.meta.idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Entry 0 gets a last try, allowed or not.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (!found_q || d0_q < best_dist_q) begin
        out_idx_q  <= '0;
        out_dist_q <= d0_q;
      end else begin
        out_idx_q  <= best_idx_q;
        out_dist_q <= best_dist_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign nearest_index_o = out_idx_q;
  assign distance_o      = out_dist_q;

  a_final_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL) |-> (!p1_vld_q && !res.vld))
    else $error("pipeline not empty at the black check");

  a_write_marks_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> valid_q[$past(entry_index_i[AW-1:0])])
    else $error("written entry not marked valid");

  a_index_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, nearest_index_o} < (IDX_W + 1)'(PALETTE_ENTRIES)))
    else $error("result index beyond the palette");

  a_dist_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (distance_o <= DIST_W'(195075)))
    else $error("distance beyond its range");

  a_no_walk_when_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (!p1_vld_q && !res.vld))
    else $error("item accepted while the walk is still running");

endmodule
